FILE: src/weighted_vector_distance_assert.svh
// ----------------------------------------------------------------------------
// Weighted vector distance assertion macros
// Shared concurrent assertion forms; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_VECTOR_DISTANCE_ASSERT_SVH
`define WEIGHTED_VECTOR_DISTANCE_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition holds in the same cycle as the trigger.
`define WVD_ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("weighted_vector_distance: same-cycle check failed");
// Condition holds in the cycle after the trigger.
`define WVD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("weighted_vector_distance: next-cycle check failed");
`else
`define WVD_ASSERT_IMPLIES(label, clk, rst, trig, cond)
`define WVD_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif
`endif

FILE: src/wvd_pkg.sv
// ----------------------------------------------------------------------------
// Weighted vector distance package
// Formats, word types, sequencer states and datapath operation codes.
// ----------------------------------------------------------------------------
package wvd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COUNT_BITS = 12;

   localparam int VALUE_W  = 32;
   localparam int WVAL_W   = VALUE_W + 1;
   localparam int PROD_W   = 2 * WVAL_W;
   localparam int WEIGHT_W = FRAC_BITS + 1;
   localparam int TOTAL_W  = COUNT_BITS + 1;
   localparam int SQ_W     = 2 * VALUE_W;
   localparam int SUMW_W   = SQ_W + 1;
   localparam int ACC_W    = 62;
   localparam int DIST_W   = 32;

   localparam int DIV_STEPS  = WEIGHT_W;
   localparam int SQRT_STEPS = ACC_W / 2;
   localparam int QR_W       = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
   localparam int SUB_W      = QR_W + 5;
   localparam int CNT_W      = $clog2(QR_W);

   localparam logic [ACC_W-1:0]    ACC_MAX    = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_a;
      logic signed [VALUE_W-1:0] value_b;
      logic [COUNT_BITS-1:0]     members_a;
      logic [COUNT_BITS-1:0]     members_b;
      logic                      first_elem;
      logic                      last_elem;
   } wvd_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } wvd_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_A,
      ST_DIV_B,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIFF,
      ST_SQUARE,
      ST_ACCUM,
      ST_SQRT,
      ST_RESP
   } wvd_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_DIV_A,
      OP_DIV_B,
      OP_MUL_A,
      OP_MUL_B,
      OP_DIFF,
      OP_SQUARE,
      OP_ACCUM,
      OP_SQRT
   } wvd_op_type;

   typedef struct packed {
      wvd_op_type op;
      logic       load;
      logic       first;
      logic       step_first;
      logic       step_last;
   } wvd_ctl_type;

endpackage

FILE: src/wvd_ctrl.sv
// ----------------------------------------------------------------------------
// Weighted vector distance sequencer
// Steps the shared datapath through division, weighting, squaring,
// accumulation and the square root, one word at a time.
// ----------------------------------------------------------------------------
`include "weighted_vector_distance_assert.svh"

module wvd_ctrl import wvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        first_elem,
   input  logic        last_elem,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output wvd_ctl_type ctl
);

   wvd_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             accept;
   logic             div_done;
   logic             sqrt_done;

   assign accept    = req_valid && !req_stall;
   assign div_done  = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign sqrt_done = (cnt_ff == CNT_W'(SQRT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = first_elem ? ST_DIV_A : ST_MUL_A;
            end
         end
         ST_DIV_A: begin
            if (div_done) begin
               state_in = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_done) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A:  state_in = ST_MUL_B;
         ST_MUL_B:  state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = last_ff ? ST_SQRT : ST_IDLE;
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (state_in != state_ff) begin
         cnt_in = '0;
      end else if (state_ff == ST_DIV_A || state_ff == ST_DIV_B || state_ff == ST_SQRT) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
      last_in = accept ? last_elem : last_ff;
   end

   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_RESP);
      ctl.op         = OP_NONE;
      ctl.load       = accept;
      ctl.first      = accept && first_elem;
      ctl.step_first = (cnt_ff == '0);
      ctl.step_last  = 1'b0;
      unique case (state_ff)
         ST_DIV_A: begin
            ctl.op        = OP_DIV_A;
            ctl.step_last = div_done;
         end
         ST_DIV_B: begin
            ctl.op        = OP_DIV_B;
            ctl.step_last = div_done;
         end
         ST_MUL_A:  ctl.op = OP_MUL_A;
         ST_MUL_B:  ctl.op = OP_MUL_B;
         ST_DIFF:   ctl.op = OP_DIFF;
         ST_SQUARE: ctl.op = OP_SQUARE;
         ST_ACCUM:  ctl.op = OP_ACCUM;
         ST_SQRT: begin
            ctl.op        = OP_SQRT;
            ctl.step_last = sqrt_done;
         end
         default:   ctl.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   `WVD_ASSERT_NEXT(a_first_word_divides, clock, reset, accept && first_elem, state_ff == ST_DIV_A)
   `WVD_ASSERT_IMPLIES(a_div_count_bound, clock, reset, state_ff == ST_DIV_A || state_ff == ST_DIV_B, cnt_ff < CNT_W'(DIV_STEPS))
   `WVD_ASSERT_NEXT(a_root_then_resp, clock, reset, state_ff == ST_SQRT && sqrt_done, state_ff == ST_RESP)

endmodule

FILE: src/wvd_datapath.sv
// ----------------------------------------------------------------------------
// Weighted vector distance datapath
// One shared multiplier and one shared trial subtractor; the subtractor
// serves the restoring weight division and the digit-by-digit square root.
// ----------------------------------------------------------------------------
`include "weighted_vector_distance_assert.svh"

module wvd_datapath import wvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  wvd_ctl_type ctl,
   input  wvd_req_type req_data,
   output wvd_rsp_type rsp_data
);

   wvd_req_type          item_ff, item_in;
   logic [WEIGHT_W-1:0]  wa_ff, wa_in;
   logic [WEIGHT_W-1:0]  wb_ff, wb_in;
   logic [ACC_W-1:0]     sum_ff, sum_in;
   logic                 ovf_ff, ovf_in;
   logic [SUB_W-1:0]     rem_ff, rem_in;
   logic [QR_W-1:0]      qr_ff, qr_in;
   logic [ACC_W-1:0]     src_ff, src_in;
   logic [WVAL_W-1:0]    wt_a_ff, wt_a_in;
   logic [WVAL_W-1:0]    wt_b_ff, wt_b_in;
   logic [WVAL_W-1:0]    mag_ff, mag_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic                 big_ff, big_in;
   wvd_rsp_type          rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0]    own;
   logic [TOTAL_W-1:0]       total;
   logic [SUB_W-1:0]         rem_base;
   logic [SUB_W-1:0]         sub_b;
   logic [SUB_W:0]           sub_d;
   logic                     ge;
   logic [QR_W-1:0]          qr_cur;
   logic [QR_W-1:0]          qr_next;
   logic signed [WVAL_W-1:0] mul_x;
   logic signed [WVAL_W-1:0] mul_y;
   logic signed [PROD_W-1:0] prod;
   logic [WVAL_W-1:0]        weighted;
   logic [WVAL_W:0]          diff;
   logic [WVAL_W:0]          diff_abs;
   logic [SUMW_W-1:0]        sum_wide;
   logic                     sat;

   assign own   = (ctl.op == OP_DIV_B) ? item_ff.members_b : item_ff.members_a;
   assign total = {1'b0, item_ff.members_a} + {1'b0, item_ff.members_b};

   // Shared trial subtractor: divisor for the division, trial root for the sqrt.
   always_comb begin
      qr_cur = ctl.step_first ? '0 : qr_ff;
      if (ctl.op == OP_SQRT) begin
         rem_base = ctl.step_first ? SUB_W'(sum_ff[ACC_W-1 -: 2])
                                   : {rem_ff[SUB_W-3:0], src_ff[ACC_W-1 -: 2]};
         sub_b    = SUB_W'({qr_cur, 2'b01});
      end else begin
         rem_base = ctl.step_first ? SUB_W'(own) : {rem_ff[SUB_W-2:0], 1'b0};
         sub_b    = SUB_W'(total);
      end
      sub_d   = {1'b0, rem_base} - {1'b0, sub_b};
      ge      = !sub_d[SUB_W];
      qr_next = {qr_cur[QR_W-2:0], ge};
   end

   // Shared multiplier: element times weight, or magnitude squared.
   always_comb begin
      unique case (ctl.op)
         OP_MUL_A: begin
            mul_x = {item_ff.value_a[VALUE_W-1], item_ff.value_a};
            mul_y = {{(WVAL_W - WEIGHT_W){1'b0}}, wa_ff};
         end
         OP_MUL_B: begin
            mul_x = {item_ff.value_b[VALUE_W-1], item_ff.value_b};
            mul_y = {{(WVAL_W - WEIGHT_W){1'b0}}, wb_ff};
         end
         default: begin
            mul_x = {1'b0, mag_ff[VALUE_W-1:0]};
            mul_y = {1'b0, mag_ff[VALUE_W-1:0]};
         end
      endcase
      prod = mul_x * mul_y;
      // The arithmetic shift floors toward minus infinity.
      weighted = prod[FRAC_BITS +: WVAL_W];
   end

   always_comb begin
      diff     = {wt_a_ff[WVAL_W-1], wt_a_ff} - {wt_b_ff[WVAL_W-1], wt_b_ff};
      diff_abs = diff[WVAL_W] ? (~diff + 1'b1) : diff;
      sum_wide = SUMW_W'(sum_ff) + {1'b0, sq_ff};
      sat      = big_ff || (sum_wide[SUMW_W-1:ACC_W] != '0);
   end

   always_comb begin
      item_in = ctl.load ? req_data : item_ff;
      wa_in   = wa_ff;
      wb_in   = wb_ff;
      sum_in  = sum_ff;
      ovf_in  = ovf_ff;
      rem_in  = rem_ff;
      qr_in   = qr_ff;
      src_in  = src_ff;
      wt_a_in = wt_a_ff;
      wt_b_in = wt_b_ff;
      mag_in  = mag_ff;
      sq_in   = sq_ff;
      big_in  = big_ff;
      rsp_in  = rsp_ff;
      if (ctl.first) begin
         sum_in = '0;
         ovf_in = 1'b0;
      end
      unique case (ctl.op)
         OP_DIV_A, OP_DIV_B: begin
            rem_in = ge ? sub_d[SUB_W-1:0] : rem_base;
            qr_in  = qr_next;
            if (ctl.step_last) begin
               if (ctl.op == OP_DIV_A) begin
                  wa_in = (total == '0) ? '0 : qr_next[WEIGHT_W-1:0];
               end else begin
                  wb_in = (total == '0) ? '0 : qr_next[WEIGHT_W-1:0];
               end
            end
         end
         OP_MUL_A:  wt_a_in = weighted;
         OP_MUL_B:  wt_b_in = weighted;
         OP_DIFF:   mag_in  = diff_abs[WVAL_W-1:0];
         OP_SQUARE: begin
            sq_in  = prod[SQ_W-1:0];
            // A magnitude of exactly two to the word width squares past the limit.
            big_in = mag_ff[VALUE_W];
         end
         OP_ACCUM: begin
            if (sat) begin
               sum_in = ACC_MAX;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_wide[ACC_W-1:0];
            end
         end
         OP_SQRT: begin
            rem_in = ge ? sub_d[SUB_W-1:0] : rem_base;
            qr_in  = qr_next;
            src_in = ctl.step_first ? {sum_ff[ACC_W-3:0], 2'b00} : {src_ff[ACC_W-3:0], 2'b00};
            if (ctl.step_last) begin
               rsp_in.distance  = DIST_W'(qr_next);
               rsp_in.saturated = ovf_ff;
               sum_in           = '0;
               ovf_in           = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wa_ff  <= '0;
         wb_ff  <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         wa_ff  <= wa_in;
         wb_ff  <= wb_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rem_ff  <= rem_in;
      qr_ff   <= qr_in;
      src_ff  <= src_in;
      wt_a_ff <= wt_a_in;
      wt_b_ff <= wt_b_in;
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      big_ff  <= big_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `WVD_ASSERT_IMPLIES(a_ovf_means_full, clock, reset, ovf_ff, sum_ff == ACC_MAX)
   `WVD_ASSERT_IMPLIES(a_weights_bounded, clock, reset, 1'b1, wa_ff <= WEIGHT_ONE && wb_ff <= WEIGHT_ONE)

endmodule

FILE: src/weighted_vector_distance.sv
// ----------------------------------------------------------------------------
// Weighted vector distance
// Weighted Euclidean distance of two cluster vectors, streamed one element
// pair per word, with a floor square root on the last pair.
//
//   Channel   Handshake             Payload
//   req       req_valid/req_stall   wvd_req_type (elements, counts, marks)
//   rsp       rsp_valid/rsp_stall   wvd_rsp_type (distance, saturated)
//
// A middle pair steps through accept, two multiplies, difference, square
// and accumulate; the two multiplies and the square share the one multiplier.
// A first pair adds the two weight divisions before the multiplies.
// A last pair adds the square root and then a response state.
// req_stall is high from accept until the word is finished and any result
// has been taken; reset is synchronous and clears weights and the sum.
// ----------------------------------------------------------------------------
module weighted_vector_distance import wvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  wvd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output wvd_rsp_type rsp_data
);

   wvd_ctl_type ctl;

   wvd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .first_elem (req_data.first_elem),
      .last_elem  (req_data.last_elem),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .ctl        (ctl)
   );

   wvd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
